FILE: src/rcsi_pkg.sv
// ----------------------------------------------------------------------------
// rcsi_pkg
// shared constants and sizing functions for the rgb cubic spline interpolator
// ----------------------------------------------------------------------------
package rcsi_pkg;

    localparam int POS_BITS_DEF  = 16;
    localparam int CHAN_BITS_DEF = 16;

    // sample parameter fraction bits and limits
    localparam int T_FRAC   = 16;
    localparam int T_LIM    = 2 ** 20;
    localparam int TW       = 22;

    // horner accumulator: clamp at +-2^40, split into low and high halves
    localparam int VW       = 42;
    localparam int VL       = 21;
    localparam int V_LIM_SH = 40;

    function automatic int div_qbits(input int chan_bits);
        int q;
        q = chan_bits + 3;
        return (q > 21) ? q : 21;
    endfunction

    // start request to done strobe, in clock cycles
    function automatic int pipe_latency(input int chan_bits);
        return div_qbits(chan_bits) + 12;
    endfunction

endpackage

FILE: src/rgb_cubic_spline_interpolator.sv
// ----------------------------------------------------------------------------
// rgb_cubic_spline_interpolator
// per-channel cubic hermite segment through knots 1 and 2, clamped to [0,1]
// ----------------------------------------------------------------------------
// One request is taken in every clock cycle; busy is never raised. Each result
// appears on the outputs with done high for a single cycle, after its request
// has passed the input staging register, the slope product register, the
// bit-per-stage divider pipeline for the sample parameter and the six slopes
// (quotient bits plus two), one coefficient stage, three horner steps of two
// stages each (partial products, then sum and clamp) and the output register.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module rgb_cubic_spline_interpolator
    import rcsi_pkg::*;
#(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int CHAN_BITS = CHAN_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [POS_BITS-1:0]      knot_pos_0,
    input  logic [POS_BITS-1:0]      knot_pos_1,
    input  logic [POS_BITS-1:0]      knot_pos_2,
    input  logic [POS_BITS-1:0]      knot_pos_3,
    input  logic [3*CHAN_BITS-1:0]   knot_color_0,
    input  logic [3*CHAN_BITS-1:0]   knot_color_1,
    input  logic [3*CHAN_BITS-1:0]   knot_color_2,
    input  logic [3*CHAN_BITS-1:0]   knot_color_3,
    input  logic [POS_BITS-1:0]      sample_pos,
    output logic                     done,
    output logic [CHAN_BITS-1:0]     red_out,
    output logic [CHAN_BITS-1:0]     green_out,
    output logic [CHAN_BITS-1:0]     blue_out,
    output logic                     degenerate
);

    localparam int P   = POS_BITS;
    localparam int C   = CHAN_BITS;
    localparam int CF  = C - 1;
    localparam int DW  = P;
    localparam int NW  = P + ((C > T_FRAC) ? C : T_FRAC);
    localparam int QW  = div_qbits(C);
    localparam int LD  = QW + 2;
    localparam int KW  = CF + 6;
    localparam int SLOPE_LIM = 2 ** (CF + 3);

    localparam logic [C-1:0]         ONE_C = {1'b1, {CF{1'b0}}};
    localparam logic signed [63:0]   V_LIM = 64'sd1 <<< V_LIM_SH;
    localparam logic signed [63:0]   HALF  = 64'sd1 <<< (T_FRAC - 1);

    typedef logic signed [NW:0] num_t;
    typedef logic signed [P:0]  den_t;
    typedef logic signed [QW:0] quo_t;

    typedef struct packed {
        logic [2:0][C-1:0] y1;
        logic [2:0][C:0]   dd;
        logic [2:0]        max1;
        logic [2:0]        max2;
        logic              degen;
    } side_t;

    typedef struct packed {
        logic [TW-1:0]              t;
        logic [2:0][VW-1:0]         v;
        logic [2:0][2:0][KW-1:0]    k;
        logic                       degen;
    } ctx_t;

    typedef struct packed {
        logic [VL+TW:0]       pl;
        logic [VW-VL+TW-1:0]  ph;
    } part_t;

    // input staging
    logic [P-1:0]  x_reg [4];
    logic [P-1:0]  s_reg;
    logic [C-1:0]  y_reg [3][4];
    logic          v1_reg;

    logic [3*C-1:0] col [4];

    assign busy   = 1'b0;
    assign col[0] = knot_color_0;
    assign col[1] = knot_color_1;
    assign col[2] = knot_color_2;
    assign col[3] = knot_color_3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= knot_pos_0;
        x_reg[1] <= knot_pos_1;
        x_reg[2] <= knot_pos_2;
        x_reg[3] <= knot_pos_3;
        s_reg    <= sample_pos;
        for (int c = 0; c < 3; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                y_reg[c][i] <= (col[i][C*(2-c) +: C] > ONE_C) ? ONE_C : col[i][C*(2-c) +: C];
            end
        end
    end

    // spacings, maximum tests and slope numerators
    den_t  h_next, d1_next, d2_next, u_next;
    side_t side_next;
    num_t  na_next [3];
    num_t  nb_next [3];

    always_comb
    begin
        logic signed [C:0]       dy0;
        logic signed [C:0]       dy1;
        logic signed [P+C+1:0]   pa;
        logic signed [P+C+1:0]   pb;
        h_next  = $signed({1'b0, x_reg[2]}) - $signed({1'b0, x_reg[1]});
        d1_next = $signed({1'b0, x_reg[2]}) - $signed({1'b0, x_reg[0]});
        d2_next = $signed({1'b0, x_reg[3]}) - $signed({1'b0, x_reg[1]});
        u_next  = $signed({1'b0, s_reg})    - $signed({1'b0, x_reg[1]});
        side_next.degen = (h_next == '0);
        for (int c = 0; c < 3; c++)
        begin
            dy0 = $signed({1'b0, y_reg[c][2]}) - $signed({1'b0, y_reg[c][0]});
            dy1 = $signed({1'b0, y_reg[c][3]}) - $signed({1'b0, y_reg[c][1]});
            pa  = h_next * dy0;
            pb  = h_next * dy1;
            na_next[c] = num_t'(pa);
            nb_next[c] = num_t'(pb);
            side_next.y1[c]   = y_reg[c][1];
            side_next.dd[c]   = $signed({1'b0, y_reg[c][2]}) - $signed({1'b0, y_reg[c][1]});
            side_next.max1[c] = (y_reg[c][1] >= y_reg[c][0]) && (y_reg[c][1] >= y_reg[c][2]);
            side_next.max2[c] = (y_reg[c][2] >= y_reg[c][1]) && (y_reg[c][2] >= y_reg[c][3]);
            if ((!side_next.max1[c] && d1_next == '0) || (!side_next.max2[c] && d2_next == '0))
            begin
                side_next.degen = 1'b1;
            end
        end
    end

    num_t  nt_reg;
    num_t  na_reg [3];
    num_t  nb_reg [3];
    den_t  h_reg, d1_reg, d2_reg;
    side_t s2_reg;
    logic  v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nt_reg <= num_t'(u_next) <<< T_FRAC;
        na_reg <= na_next;
        nb_reg <= nb_next;
        h_reg  <= h_next;
        d1_reg <= d1_next;
        d2_reg <= d2_next;
        s2_reg <= side_next;
    end

    // dividers
    quo_t t_q;
    quo_t a_q [3];
    quo_t b_q [3];

    rcsi_div #(.NW(NW), .DW(DW), .QW(QW), .LIM(T_LIM)) u_div_t (
        .clk (clk),
        .num (nt_reg),
        .den (h_reg),
        .quo (t_q)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_slope
        rcsi_div #(.NW(NW), .DW(DW), .QW(QW), .LIM(SLOPE_LIM)) u_div_a (
            .clk (clk),
            .num (na_reg[c]),
            .den (d1_reg),
            .quo (a_q[c])
        );
        rcsi_div #(.NW(NW), .DW(DW), .QW(QW), .LIM(SLOPE_LIM)) u_div_b (
            .clk (clk),
            .num (nb_reg[c]),
            .den (d2_reg),
            .quo (b_q[c])
        );
    end

    side_t side_reg [0:LD-1];
    logic  sv_reg   [0:LD-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LD; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            sv_reg[0] <= v2_reg;
            for (int k = 1; k < LD; k++)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= s2_reg;
        for (int k = 1; k < LD; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // hermite coefficients
    ctx_t ctx0_next;

    always_comb
    begin
        logic signed [KW-1:0] a;
        logic signed [KW-1:0] b;
        logic signed [KW-1:0] dd;
        logic signed [KW-1:0] qb;
        logic signed [KW-1:0] qc;
        ctx0_next.t     = TW'(t_q);
        ctx0_next.degen = side_reg[LD-1].degen;
        for (int c = 0; c < 3; c++)
        begin
            a  = side_reg[LD-1].max1[c] ? '0 : KW'(a_q[c]);
            b  = side_reg[LD-1].max2[c] ? '0 : KW'(b_q[c]);
            dd = KW'($signed(side_reg[LD-1].dd[c]));
            qb = KW'(3 * dd - 2 * a - b);
            qc = KW'(a + b - 2 * dd);
            ctx0_next.v[c]    = VW'(qc);
            ctx0_next.k[c][0] = qb;
            ctx0_next.k[c][1] = a;
            ctx0_next.k[c][2] = KW'(side_reg[LD-1].y1[c]);
        end
    end

    // horner evaluation, two stages per step
    ctx_t  ctx_reg  [0:6];
    logic  cv_reg   [0:6];
    part_t part_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= 6; k++)
            begin
                cv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            cv_reg[0] <= sv_reg[LD-1];
            for (int k = 1; k <= 6; k++)
            begin
                cv_reg[k] <= cv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[0] <= ctx0_next;
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_step
        part_t part_next [3];
        ctx_t  sum_next;

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                part_next[c].pl = $signed({1'b0, ctx_reg[2*j].v[c][VL-1:0]})
                                  * $signed(ctx_reg[2*j].t);
                part_next[c].ph = $signed(ctx_reg[2*j].v[c][VW-1:VL])
                                  * $signed(ctx_reg[2*j].t);
            end
        end

        always_comb
        begin
            logic signed [63:0] acc;
            sum_next = ctx_reg[2*j+1];
            for (int c = 0; c < 3; c++)
            begin
                acc = (64'($signed(part_reg[j][c].ph)) <<< VL)
                      + 64'($signed(part_reg[j][c].pl)) + HALF;
                acc = (acc >>> T_FRAC) + 64'($signed(ctx_reg[2*j+1].k[c][j]));
                if (acc > V_LIM)
                begin
                    acc = V_LIM;
                end
                else if (acc < -V_LIM)
                begin
                    acc = -V_LIM;
                end
                sum_next.v[c] = VW'(acc);
            end
        end

        always_ff @(posedge clk)
        begin
            part_reg[j]    <= part_next;
            ctx_reg[2*j+1] <= ctx_reg[2*j];
            ctx_reg[2*j+2] <= sum_next;
        end
    end

    // output clamp
    logic [C-1:0] res_next [3];
    logic [C-1:0] res_reg  [3];
    logic         degen_reg;
    logic         done_reg;

    always_comb
    begin
        logic signed [VW-1:0] v;
        for (int c = 0; c < 3; c++)
        begin
            v = $signed(ctx_reg[6].v[c]);
            if (ctx_reg[6].degen || v < 0)
            begin
                res_next[c] = '0;
            end
            else if (v > $signed(VW'(ONE_C)))
            begin
                res_next[c] = ONE_C;
            end
            else
            begin
                res_next[c] = v[C-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cv_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        degen_reg <= ctx_reg[6].degen;
    end

    assign done       = done_reg;
    assign red_out    = res_reg[0];
    assign green_out  = res_reg[1];
    assign blue_out   = res_reg[2];
    assign degenerate = degen_reg;

endmodule

FILE: src/rcsi_div.sv
// ----------------------------------------------------------------------------
// rcsi_div
// pipelined signed divider, one quotient bit per stage, rounded to nearest
// with ties away from zero, magnitude saturated to LIM
// ----------------------------------------------------------------------------
module rcsi_div #(
    parameter int NW  = 32,
    parameter int DW  = 16,
    parameter int QW  = 21,
    parameter int LIM = 1048576
) (
    input  logic                 clk,
    input  logic signed [NW:0]   num,
    input  logic signed [DW:0]   den,
    output logic signed [QW:0]   quo
);

    localparam logic [QW-1:0] LIM_Q = QW'(LIM);

    logic [NW-1:0] un_next;
    logic [DW-1:0] ud_next;
    logic [NW:0]   nr_next;
    logic          ovf_next;

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [DW-1:0] ud_reg  [0:QW];
    logic          neg_reg [0:QW];
    logic          ovf_reg [0:QW];

    logic [QW-1:0]      mag_next;
    logic signed [QW:0] quo_reg;

    always_comb
    begin
        un_next  = num[NW] ? NW'(-num) : NW'(num);
        ud_next  = den[DW] ? DW'(-den) : DW'(den);
        nr_next  = (NW+1)'(un_next) + (NW+1)'(ud_next >> 1);
        ovf_next = (nr_next >> QW) >= (NW+1)'(ud_next);
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DW'(nr_next >> QW);
        low_reg[0] <= nr_next[QW-1:0];
        q_reg[0]   <= '0;
        ud_reg[0]  <= ud_next;
        neg_reg[0] <= num[NW] ^ den[DW];
        ovf_reg[0] <= ovf_next;
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [DW:0] r2;
        logic        ge;

        always_comb
        begin
            r2 = {rem_reg[k-1], low_reg[k-1][QW-1]};
            ge = r2 >= {1'b0, ud_reg[k-1]};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? DW'(r2 - {1'b0, ud_reg[k-1]}) : DW'(r2);
            low_reg[k] <= low_reg[k-1] << 1;
            q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
            ud_reg[k]  <= ud_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    always_comb
    begin
        mag_next = (ovf_reg[QW] || q_reg[QW] > LIM_Q) ? LIM_Q : q_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= neg_reg[QW] ? -$signed({1'b0, mag_next}) : $signed({1'b0, mag_next});
    end

    assign quo = quo_reg;

endmodule

FILE: src/rcsi_checker.sv
// ----------------------------------------------------------------------------
// rcsi_checker
// port-level checks for the rgb cubic spline interpolator
// ----------------------------------------------------------------------------
module rcsi_checker
    import rcsi_pkg::*;
#(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int CHAN_BITS = CHAN_BITS_DEF
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [POS_BITS-1:0]      knot_pos_1,
    input logic [POS_BITS-1:0]      knot_pos_2,
    input logic                     done,
    input logic [CHAN_BITS-1:0]     red_out,
    input logic [CHAN_BITS-1:0]     green_out,
    input logic [CHAN_BITS-1:0]     blue_out,
    input logic                     degenerate
);

    localparam int LAT = pipe_latency(CHAN_BITS);
    localparam logic [CHAN_BITS-1:0] ONE_C = {1'b1, {(CHAN_BITS-1){1'b0}}};

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without request");

    a_zero_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && knot_pos_1 == knot_pos_2) |-> ##LAT (done && degenerate))
        else $error("zero interval not flagged");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (red_out == '0 && green_out == '0 && blue_out == '0))
        else $error("degenerate result not zero");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red_out <= ONE_C && green_out <= ONE_C && blue_out <= ONE_C))
        else $error("channel above one");

endmodule

bind rgb_cubic_spline_interpolator rcsi_checker #(
    .POS_BITS  (POS_BITS),
    .CHAN_BITS (CHAN_BITS)
) u_rcsi_checker (.*);

FILE: dv/rgb_cubic_spline_interpolator_tb.sv
// ----------------------------------------------------------------------------
// rgb_cubic_spline_interpolator_tb
// Drives pixel requests through a table of directed cases and then random
// knot sets, with random gaps between requests. Each done strobe is checked
// against a typed row value or a bit-exact fixed-point hermite segment model.
// ----------------------------------------------------------------------------
module rgb_cubic_spline_interpolator_tb;
    import rcsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 930;
    localparam int NUM_DIRECTED = 13;
    localparam longint CHAN_ONE = 32768;

    typedef struct packed {
        logic [3:0][15:0] pos;
        logic [3:0][47:0] col;
        logic [15:0]      s;
    } pixel_req_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic        deg;
    } pixel_t;

    typedef struct packed {
        pixel_req_t rq;
        logic       typed;
        pixel_t     want;
    } pixel_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [15:0]      knot_pos_0, knot_pos_1, knot_pos_2, knot_pos_3;
    logic [47:0]      knot_color_0, knot_color_1, knot_color_2, knot_color_3;
    logic [15:0]      sample_pos;
    logic             done;
    logic [15:0]      red_out, green_out, blue_out;
    logic             degenerate;

    pixel_t     pending_pixels[$];
    pixel_row_t directed_rows[NUM_DIRECTED];
    int         errors = 0;

    rgb_cubic_spline_interpolator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .knot_pos_0(knot_pos_0), .knot_pos_1(knot_pos_1),
        .knot_pos_2(knot_pos_2), .knot_pos_3(knot_pos_3),
        .knot_color_0(knot_color_0), .knot_color_1(knot_color_1),
        .knot_color_2(knot_color_2), .knot_color_3(knot_color_3),
        .sample_pos(sample_pos), .done(done),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint div_nearest(longint n, longint d);
        longint an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = (an + ad / 2) / ad;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint horner_mac(longint v, longint t, longint k);
        longint p, lim;
        lim = longint'(1) <<< 40;
        p = v * t + 32768;
        return clampl((p >>> 16) + k, -lim, lim);
    endfunction

    function automatic pixel_t predict_pixel(pixel_req_t rq);
        longint x[4];
        longint y[3][4];
        longint res[3];
        longint h, d1, d2, t, a, b, dd, v;
        logic   degen, m1, m2;
        pixel_t px;
        for (int i = 0; i < 4; i++)
        begin
            x[i] = longint'(rq.pos[i]);
            for (int c = 0; c < 3; c++)
                y[c][i] = clampl(longint'(rq.col[i][(2 - c) * 16 +: 16]), 0, CHAN_ONE);
        end
        h = x[2] - x[1];
        d1 = x[2] - x[0];
        d2 = x[3] - x[1];
        degen = (h == 0);
        for (int c = 0; c < 3; c++)
        begin
            m1 = y[c][1] >= y[c][0] && y[c][1] >= y[c][2];
            m2 = y[c][2] >= y[c][1] && y[c][2] >= y[c][3];
            if ((!m1 && d1 == 0) || (!m2 && d2 == 0))
                degen = 1'b1;
        end
        for (int c = 0; c < 3; c++)
            res[c] = 0;
        if (!degen)
        begin
            t = clampl(div_nearest((longint'(rq.s) - x[1]) * 65536, h),
                       -(longint'(16) <<< 16), longint'(16) <<< 16);
            for (int c = 0; c < 3; c++)
            begin
                a = 0;
                b = 0;
                if (!(y[c][1] >= y[c][0] && y[c][1] >= y[c][2]))
                    a = clampl(div_nearest(h * (y[c][2] - y[c][0]), d1),
                               -8 * CHAN_ONE, 8 * CHAN_ONE);
                if (!(y[c][2] >= y[c][1] && y[c][2] >= y[c][3]))
                    b = clampl(div_nearest(h * (y[c][3] - y[c][1]), d2),
                               -8 * CHAN_ONE, 8 * CHAN_ONE);
                dd = y[c][2] - y[c][1];
                v = a + b - 2 * dd;
                v = horner_mac(v, t, 3 * dd - 2 * a - b);
                v = horner_mac(v, t, a);
                v = horner_mac(v, t, y[c][1]);
                res[c] = clampl(v, 0, CHAN_ONE);
            end
        end
        px.r = res[0][15:0];
        px.g = res[1][15:0];
        px.b = res[2][15:0];
        px.deg = degen;
        return px;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (red_out !== want.r)
                    report("red_out", longint'(red_out), longint'(want.r));
                if (green_out !== want.g)
                    report("green_out", longint'(green_out), longint'(want.g));
                if (blue_out !== want.b)
                    report("blue_out", longint'(blue_out), longint'(want.b));
                if (degenerate !== want.deg)
                    report("degenerate", longint'(degenerate), longint'(want.deg));
            end
        end
    end

    task automatic send_pixel(pixel_req_t rq, pixel_t want);
        int gap;
        knot_pos_0 <= rq.pos[0];
        knot_pos_1 <= rq.pos[1];
        knot_pos_2 <= rq.pos[2];
        knot_pos_3 <= rq.pos[3];
        knot_color_0 <= rq.col[0];
        knot_color_1 <= rq.col[1];
        knot_color_2 <= rq.col[2];
        knot_color_3 <= rq.col[3];
        sample_pos <= rq.s;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(want);
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [47:0] random_color(int mode);
        logic [47:0] col;
        for (int c = 0; c < 3; c++)
            col[c * 16 +: 16] = (mode == 0) ? 16'($urandom) :
                                16'($urandom_range(0, 32768));
        return col;
    endfunction

    function automatic pixel_req_t random_request();
        pixel_req_t rq;
        int         kind, h;
        kind = int'($urandom_range(0, 9));
        rq.pos[0] = 16'($urandom);
        rq.pos[1] = 16'(rq.pos[0] + 16'($urandom_range(1, 8000)));
        rq.pos[2] = 16'(rq.pos[1] + 16'($urandom_range(1, 8000)));
        rq.pos[3] = 16'(rq.pos[2] + 16'($urandom_range(1, 8000)));
        h = int'(16'(rq.pos[2] - rq.pos[1]));
        rq.s = 16'(int'(rq.pos[1]) - h / 4 + int'($urandom_range(0, h * 3 / 2)));
        for (int i = 0; i < 4; i++)
            rq.col[i] = random_color(int'($urandom_range(0, 4)));
        case (kind)
            7:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rq.pos[i] = 16'($urandom);
                    rq.col[i] = 48'({$urandom, $urandom});
                end
                rq.s = 16'($urandom);
            end
            8:
                case ($urandom_range(0, 2))
                    0: rq.pos[0] = rq.pos[2];
                    1: rq.pos[3] = rq.pos[1];
                    default: rq.pos[2] = rq.pos[1];
                endcase
            9:
            begin
                rq.col[0] = random_color(1) >> 2;
                rq.col[3] = random_color(1) >> 2;
                rq.col[1] = rq.col[0] | 48'h4000_4000_4000;
                rq.col[2] = rq.col[3] | 48'h4000_4000_4000;
                rq.s = 16'($urandom);
            end
            default: ;
        endcase
        return rq;
    endfunction

    initial
    begin
        pixel_req_t rq;
        // rows: pos {x3,x2,x1,x0}, col {c3,c2,c1,c0}, sample
        directed_rows[0] = '{'{64'd0, 192'd0, 16'd0}, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}};
        directed_rows[1] = '{'{{16'd300, 16'd200, 16'd100, 16'd0},
            {4{48'h8000_8000_8000}}, 16'd150}, 1'b1, '{16'h8000, 16'h8000, 16'h8000, 1'b0}};
        directed_rows[2] = '{'{{16'd300, 16'd200, 16'd100, 16'd0},
            {4{48'hFFFF_FFFF_FFFF}}, 16'd150}, 1'b1, '{16'h8000, 16'h8000, 16'h8000, 1'b0}};
        directed_rows[3] = '{'{{16'd300, 16'd200, 16'd100, 16'd0},
            {48'd0, 48'd0, 48'h03E8_07D0_0BB8, 48'd0}, 16'd100}, 1'b1,
            '{16'd1000, 16'd2000, 16'd3000, 1'b0}};
        directed_rows[4] = '{'{{16'd300, 16'd200, 16'd100, 16'd200},
            {48'h0BB8_0BB8_0BB8, 48'h07D0_07D0_07D0, 48'h03E8_03E8_03E8, 48'd0}, 16'd150},
            1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}};
        directed_rows[5] = '{'{{16'd100, 16'd200, 16'd100, 16'd0},
            {48'h0BB8_0BB8_0BB8, 48'h07D0_07D0_07D0, 48'h03E8_03E8_03E8, 48'd0}, 16'd150},
            1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}};
        directed_rows[6] = '{'{{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
            {4{48'hFFFF_FFFF_FFFF}}, 16'hFFFF}, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}};
        directed_rows[7] = '{'{{16'hFFFF, 16'hFFFF, 16'd1, 16'd0},
            {48'h8000_8000_8000, 48'h6000_4000_2000, 48'h1000_0800_0400, 48'd0}, 16'hFFFF},
            1'b0, '0};
        directed_rows[8] = '{'{{16'd0, 16'd100, 16'd200, 16'd300},
            {48'h8000_0000_4000, 48'h6000_1000_3000, 48'h2000_7000_1000, 48'h0000_8000_0100},
            16'd150}, 1'b0, '0};
        directed_rows[9] = '{'{{16'd30, 16'd20, 16'd10, 16'd0},
            {48'h8000_8000_8000, 48'h6000_6000_6000, 48'h1000_1000_1000, 48'd0}, 16'hFFFF},
            1'b0, '0};
        directed_rows[10] = '{'{{16'hFFFF, 16'd65520, 16'd65510, 16'd65500},
            {48'd0, 48'h1000_2000_3000, 48'h7000_6000_5000, 48'h8000_8000_8000}, 16'd0},
            1'b0, '0};
        directed_rows[11] = '{'{{16'd65535, 16'd65534, 16'd1, 16'd65533},
            {48'h8000_0000_8000, 48'h8000_0000_8000, 48'h0000_8000_0000, 48'h0000_8000_0000},
            16'd30000}, 1'b0, '0};
        directed_rows[12] = '{'{{16'd100, 16'd200, 16'd100, 16'd200},
            {48'd0, 48'h1388_1388_1388, 48'h1388_1388_1388, 48'd0}, 16'd150}, 1'b0, '0};

        rst_n = 1'b0;
        start = 1'b0;
        {knot_pos_0, knot_pos_1, knot_pos_2, knot_pos_3, sample_pos} = '0;
        {knot_color_0, knot_color_1, knot_color_2, knot_color_3} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].rq, directed_rows[i].typed ?
                       directed_rows[i].want : predict_pixel(directed_rows[i].rq));
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            rq = random_request();
            send_pixel(rq, predict_pixel(rq));
        end
        start <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (pipe_latency(CHAN_BITS_DEF) + 8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
